### src/text_terminal_window_engine_macros.svh
// Assertion macros shared by the terminal engine.
`ifndef TEXT_TERMINAL_WINDOW_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_WINDOW_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define TTW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define TTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/ttw_pkg.sv
package ttw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_WIDTH      = 4;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  localparam int OP_W       = 2;
  localparam int CODE_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = 16;
  localparam int TAB_CNT_W  = $clog2(TAB_WIDTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] COL_MAX   = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [COL_W:0]   COL_LIMIT = (COL_W + 1)'(SCREEN_COLUMNS);

  // operations
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // control characters
  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd4;

  // reset values
  localparam logic [COLOR_W-1:0] RST_TEXT_COLOR    = 8'h07;
  localparam logic [ROW_W-1:0]   RST_WINDOW_TOP    = 5'd3;
  localparam logic [ROW_W-1:0]   RST_WINDOW_BOTTOM = 5'd20;
  localparam logic [COL_W-1:0]   RST_WINDOW_LEFT   = 7'd3;
  localparam logic [COL_W-1:0]   RST_WINDOW_RIGHT  = 7'd76;
  localparam logic [ROW_W-1:0]   RST_CURSOR_ROW    = 5'd3;
  localparam logic [COL_W-1:0]   RST_CURSOR_COL    = 7'd3;
  localparam logic [CELL_W-1:0]  RST_CELL          = {RST_TEXT_COLOR, CHAR_SPACE};

  // decoded request kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_PUT       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAB       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd6;

  // datapath commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NONE     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INIT     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ACCEPT   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_EXEC     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TAB      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_READ_CAP = 4'd5;
  localparam logic [CMD_W-1:0] CMD_COPY     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DRAIN    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FILL     = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             load_out;
  } ttw_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              scroll;
    logic              copy_none;
    logic              tab_done;
    logic              copy_last;
    logic              walk_last;
    logic              init_last;
  } ttw_stat_t;

endpackage

### src/ttw_in_if.sv
interface ttw_in_if;
  import ttw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CODE_W-1:0] char_code;
  logic [COL_W-1:0]  target_column;
  logic [ROW_W-1:0]  target_row;

  modport source (output valid, operation, char_code, target_column, target_row,
                  input ready);
  modport sink (input valid, operation, char_code, target_column, target_row,
                output ready);
endinterface

### src/ttw_out_if.sv
interface ttw_out_if;
  import ttw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row_out;
  logic [COL_W-1:0]  cursor_column_out;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  modport source (output valid, cursor_row_out, cursor_column_out, cell_data, scrolled,
                  input ready);
  modport sink (input valid, cursor_row_out, cursor_column_out, cell_data, scrolled,
                output ready);
endinterface

### src/ttw_cfg_if.sv
interface ttw_cfg_if;
  import ttw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/ttw_ctrl.sv
`include "text_terminal_window_engine_macros.svh"

module ttw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ttw_pkg::ttw_stat_t stat,
  output ttw_pkg::ttw_cmd_t  cmd
);
  import ttw_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_INIT  = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] S_EXEC  = 4'd2;
  localparam logic [ST_W-1:0] S_TAB   = 4'd3;
  localparam logic [ST_W-1:0] S_READ  = 4'd4;
  localparam logic [ST_W-1:0] S_COPY  = 4'd5;
  localparam logic [ST_W-1:0] S_DRAIN = 4'd6;
  localparam logic [ST_W-1:0] S_FILL  = 4'd7;
  localparam logic [ST_W-1:0] S_CLEAR = 4'd8;
  localparam logic [ST_W-1:0] S_DONE  = 4'd9;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = CMD_NONE;
    cmd.load_out = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op = CMD_INIT;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_ACCEPT;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op = CMD_EXEC;
        case (stat.kind)
          KIND_TAB:   state_nxt = S_TAB;
          KIND_READ:  state_nxt = S_READ;
          KIND_CLEAR: state_nxt = S_CLEAR;
          default: begin
            if (stat.scroll) begin
              state_nxt = stat.copy_none ? S_FILL : S_COPY;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end
      S_TAB: begin
        cmd.op = CMD_TAB;
        if (stat.tab_done) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.op    = CMD_READ_CAP;
        state_nxt = S_DONE;
      end
      S_COPY: begin
        cmd.op = CMD_COPY;
        if (stat.copy_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.op    = CMD_DRAIN;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.op = CMD_FILL;
        if (stat.walk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (stat.walk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TTW_ASSERT_SAME(a_rsp_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "response raised outside completion")
  `TTW_ASSERT_SAME(a_no_rsp_in_init, clk, rst_n, state_r == S_INIT, !out_valid_r, "response during clearing pass")
  `TTW_ASSERT_NEXT(a_done_loads, clk, rst_n, state_r == S_DONE && out_free, out_valid_r && state_r == S_IDLE, "completion did not load response")

endmodule

### src/ttw_datapath.sv
`include "text_terminal_window_engine_macros.svh"

module ttw_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [ttw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ttw_pkg::OP_W-1:0]       in_operation,
  input  logic [ttw_pkg::CODE_W-1:0]     in_char_code,
  input  logic [ttw_pkg::COL_W-1:0]      in_target_column,
  input  logic [ttw_pkg::ROW_W-1:0]      in_target_row,
  input  ttw_pkg::ttw_cmd_t              cmd,
  output ttw_pkg::ttw_stat_t             stat,
  output logic [ttw_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [ttw_pkg::COL_W-1:0]      out_cursor_column,
  output logic [ttw_pkg::CELL_W-1:0]     out_cell_data,
  output logic                           out_scrolled
);
  import ttw_pkg::*;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
  endfunction

  // configuration
  logic [COLOR_W-1:0] color_r;
  logic [ROW_W-1:0]   top_r, bottom_r;
  logic [COL_W-1:0]   left_r, right_r;

  // effective window
  logic [ROW_W-1:0] top_sat, eff_top, eff_bot;
  logic [COL_W-1:0] left_sat, eff_left, eff_right;

  // latched request
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [COL_W-1:0]  tcol_r, tcol_nxt;
  logic [ROW_W-1:0]  trow_r, trow_nxt;

  // cursor and sequencing
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [TAB_CNT_W-1:0] tab_left_r, tab_left_nxt;
  logic [ROW_W-1:0]     walk_row_r, walk_row_nxt;
  logic [COL_W-1:0]     walk_col_r, walk_col_nxt;
  logic [ADDR_W-1:0]    init_cnt_r, init_cnt_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic                 scr_r, scr_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;

  // response register
  logic [ROW_W-1:0]  orow_r;
  logic [COL_W-1:0]  ocol_r;
  logic [CELL_W-1:0] ocell_r;
  logic              oscr_r;

  // screen store
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_rd_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  logic [KIND_W-1:0] kind;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [COL_W-1:0]  col_dec;
  logic              wrap, nl_over, scroll_hit, copy_none, tab_done;
  logic [CELL_W-1:0] blank;

  assign eff_bot   = (bottom_r > ROW_MAX) ? ROW_MAX : bottom_r;
  assign top_sat   = (top_r > ROW_MAX) ? ROW_MAX : top_r;
  assign eff_top   = (top_sat > eff_bot) ? eff_bot : top_sat;
  assign eff_right = (right_r > COL_MAX) ? COL_MAX : right_r;
  assign left_sat  = (left_r > COL_MAX) ? COL_MAX : left_r;
  assign eff_left  = (left_sat > eff_right) ? eff_right : left_sat;

  assign blank = {color_r, CHAR_SPACE};

  always_comb begin
    case (op_r)
      OP_PUT: begin
        if (code_r == CHAR_NEWLINE) begin
          kind = KIND_NEWLINE;
        end else if (code_r == CHAR_BACKSPACE) begin
          kind = KIND_BACKSPACE;
        end else if (code_r == CHAR_TAB) begin
          kind = KIND_TAB;
        end else begin
          kind = KIND_PUT;
        end
      end
      OP_SET:   kind = KIND_SET;
      OP_READ:  kind = KIND_READ;
      OP_CLEAR: kind = KIND_CLEAR;
      default:  kind = KIND_SET;
    endcase
  end

  assign col_inc    = {1'b0, col_r} + (COL_W + 1)'(1);
  assign row_inc    = {1'b0, row_r} + (ROW_W + 1)'(1);
  assign col_dec    = col_r - COL_W'(1);
  assign wrap       = col_inc > {1'b0, eff_right};
  assign nl_over    = row_inc > {1'b0, eff_bot};
  assign scroll_hit = (((kind == KIND_PUT) && wrap) || (kind == KIND_NEWLINE)) && nl_over;
  assign copy_none  = (eff_top == eff_bot);
  assign tab_done   = (tab_left_r == '0) || (col_r > eff_right);

  assign stat.kind      = kind;
  assign stat.scroll    = scroll_hit;
  assign stat.copy_none = copy_none;
  assign stat.tab_done  = tab_done;
  assign stat.copy_last = (walk_col_r == eff_right) &&
                          (({1'b0, walk_row_r} + (ROW_W + 1)'(1)) == {1'b0, eff_bot});
  assign stat.walk_last = (walk_col_r == eff_right) && (walk_row_r == eff_bot);
  assign stat.init_last = (init_cnt_r == ADDR_W'(CELL_COUNT - 1));

  always_comb begin
    op_nxt         = op_r;
    code_nxt       = code_r;
    tcol_nxt       = tcol_r;
    trow_nxt       = trow_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    tab_left_nxt   = tab_left_r;
    walk_row_nxt   = walk_row_r;
    walk_col_nxt   = walk_col_r;
    init_cnt_nxt   = init_cnt_r;
    pend_valid_nxt = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    scr_nxt        = scr_r;
    cell_nxt       = cell_r;
    wr_en          = 1'b0;
    wr_addr        = cell_addr(row_r, col_r);
    wr_data        = {color_r, code_r};
    rd_addr        = cell_addr(trow_r, tcol_r);

    // copy write-back, in the cycle after its read
    if (pend_valid_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = mem_rd_r;
    end

    case (cmd.op)
      CMD_INIT: begin
        wr_en        = 1'b1;
        wr_addr      = init_cnt_r;
        wr_data      = RST_CELL;
        init_cnt_nxt = init_cnt_r + ADDR_W'(1);
      end
      CMD_ACCEPT: begin
        op_nxt   = in_operation;
        code_nxt = in_char_code;
        tcol_nxt = (in_target_column > COL_MAX) ? COL_MAX : in_target_column;
        trow_nxt = (in_target_row > ROW_MAX) ? ROW_MAX : in_target_row;
        scr_nxt  = 1'b0;
        cell_nxt = '0;
      end
      CMD_EXEC: begin
        case (kind)
          KIND_PUT, KIND_NEWLINE: begin
            if (kind == KIND_PUT) begin
              wr_en   = ({1'b0, col_r} < COL_LIMIT);
              col_nxt = col_inc[COL_W-1:0];
            end
            if ((kind == KIND_NEWLINE) || wrap) begin
              col_nxt = eff_left;
              if (nl_over) begin
                row_nxt      = eff_bot;
                scr_nxt      = 1'b1;
                walk_row_nxt = copy_none ? eff_bot : eff_top;
                walk_col_nxt = eff_left;
              end else begin
                row_nxt = row_inc[ROW_W-1:0];
              end
            end
          end
          KIND_BACKSPACE: begin
            if (col_r > eff_left) begin
              col_nxt = col_dec;
              wr_en   = ({1'b0, col_dec} < COL_LIMIT);
              wr_addr = cell_addr(row_r, col_dec);
              wr_data = blank;
            end
          end
          KIND_TAB: begin
            tab_left_nxt = TAB_CNT_W'(TAB_WIDTH) - TAB_CNT_W'(col_r % TAB_WIDTH);
          end
          KIND_SET: begin
            row_nxt = trow_r;
            col_nxt = tcol_r;
          end
          KIND_CLEAR: begin
            row_nxt      = eff_top;
            col_nxt      = eff_left;
            walk_row_nxt = eff_top;
            walk_col_nxt = eff_left;
          end
          default: ;  // read: address already on rd_addr
        endcase
      end
      CMD_TAB: begin
        if (!tab_done) begin
          wr_en        = ({1'b0, col_r} < COL_LIMIT);
          wr_data      = blank;
          col_nxt      = col_inc[COL_W-1:0];
          tab_left_nxt = tab_left_r - TAB_CNT_W'(1);
        end
      end
      CMD_READ_CAP: begin
        cell_nxt = mem_rd_r;
      end
      CMD_COPY: begin
        rd_addr        = cell_addr(walk_row_r + ROW_W'(1), walk_col_r);
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = cell_addr(walk_row_r, walk_col_r);
        if (walk_col_r == eff_right) begin
          walk_col_nxt = eff_left;
          walk_row_nxt = walk_row_r + ROW_W'(1);
        end else begin
          walk_col_nxt = walk_col_r + COL_W'(1);
        end
      end
      CMD_DRAIN: begin
        walk_row_nxt = eff_bot;
        walk_col_nxt = eff_left;
      end
      CMD_FILL, CMD_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(walk_row_r, walk_col_r);
        wr_data = blank;
        if (walk_col_r == eff_right) begin
          walk_col_nxt = eff_left;
          walk_row_nxt = walk_row_r + ROW_W'(1);
        end else begin
          walk_col_nxt = walk_col_r + COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r      <= RST_TEXT_COLOR;
      top_r        <= RST_WINDOW_TOP;
      bottom_r     <= RST_WINDOW_BOTTOM;
      left_r       <= RST_WINDOW_LEFT;
      right_r      <= RST_WINDOW_RIGHT;
      row_r        <= RST_CURSOR_ROW;
      col_r        <= RST_CURSOR_COL;
      init_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TEXT_COLOR:    color_r  <= cfg_data[COLOR_W-1:0];
          REG_WINDOW_TOP:    top_r    <= cfg_data[ROW_W-1:0];
          REG_WINDOW_BOTTOM: bottom_r <= cfg_data[ROW_W-1:0];
          REG_WINDOW_LEFT:   left_r   <= cfg_data[COL_W-1:0];
          REG_WINDOW_RIGHT:  right_r  <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      init_cnt_r   <= init_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    code_r      <= code_nxt;
    tcol_r      <= tcol_nxt;
    trow_r      <= trow_nxt;
    tab_left_r  <= tab_left_nxt;
    walk_row_r  <= walk_row_nxt;
    walk_col_r  <= walk_col_nxt;
    pend_addr_r <= pend_addr_nxt;
    scr_r       <= scr_nxt;
    cell_r      <= cell_nxt;
    if (cmd.load_out) begin
      orow_r  <= row_r;
      ocol_r  <= col_r;
      ocell_r <= cell_r;
      oscr_r  <= scr_r;
    end
  end

  assign out_cursor_row    = orow_r;
  assign out_cursor_column = ocol_r;
  assign out_cell_data     = ocell_r;
  assign out_scrolled      = oscr_r;

  `TTW_ASSERT_SAME(a_wb_no_clash, clk, rst_n, pend_valid_r, cmd.op == CMD_COPY || cmd.op == CMD_DRAIN, "copy write-back clashes with another write")
  `TTW_ASSERT_SAME(a_row_on_screen, clk, rst_n, 1'b1, row_r <= ROW_MAX, "cursor row off the screen")
  `TTW_ASSERT_SAME(a_copy_in_window, clk, rst_n, cmd.op == CMD_COPY, walk_row_r < eff_bot, "scroll copy beyond window bottom")

endmodule

### src/text_terminal_window_engine.sv
// Sequence: put, newline, backspace and set cursor go through accept, execute and done; read
//   cell adds a capture step; tab adds a step per blank written up to the next tab stop; scroll
//   adds a copy pass over the window rows above the bottom, a drain step and a fill of the bottom
//   row (a one-row window skips copy and drain); clear blanks the whole window. One request at
//   a time: the next is taken the cycle after the response register loads, bounded by screen walks.
// Reset: synchronous, active low; a pass over all 2000 cells then fills grey spaces, no requests taken.
module text_terminal_window_engine (
  input  logic        clk,
  input  logic        rst_n,
  ttw_in_if.sink      in_ch,
  ttw_out_if.source   out_ch,
  ttw_cfg_if.sink     cfg_ch
);
  import ttw_pkg::*;

  // Controller/datapath split:
  //  - ttw_ctrl sequences each request (decode, tab steps, scroll copy/fill,
  //    window clear) and owns the response valid flag.
  //  - ttw_datapath holds the registers, cursor, screen store (one write and
  //    one registered read per cycle) and the response register.
  // Scrolling copies row r+1 into row r, each cell read in the cycle before its
  // write; a drain step completes the last write, then the bottom row is blanked.
  // Configuration writes still land during the clearing pass.

  ttw_cmd_t  cmd;
  ttw_stat_t stat;

  // Configuration writes are always taken; software only writes while idle, which the block itself does not enforce.
  assign cfg_ch.ready = 1'b1;

  ttw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttw_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .in_operation      (in_ch.operation),
    .in_char_code      (in_ch.char_code),
    .in_target_column  (in_ch.target_column),
    .in_target_row     (in_ch.target_row),
    .cmd               (cmd),
    .stat              (stat),
    .out_cursor_row    (out_ch.cursor_row_out),
    .out_cursor_column (out_ch.cursor_column_out),
    .out_cell_data     (out_ch.cell_data),
    .out_scrolled      (out_ch.scrolled)
  );

endmodule
